[sv/epl_pkg.sv]
package epl_pkg;

   localparam int LABEL_SLOTS   = 8;
   localparam int MAX_INSTANCES = 1048576;

   localparam int GROUP_W = 20;
   localparam int LABEL_W = 3;
   localparam int USED_W  = 4;
   localparam int CNT_W   = $clog2(MAX_INSTANCES + 1);

   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_INSTANCES);

   typedef struct packed {
      logic               inc;
      logic               scan;
      logic               scan_first;
      logic               in_use;
      logic [LABEL_W-1:0] idx;
   } unit_cmd_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      logic [CNT_W-1:0] r;
      if (v >= CNT_MAX) r = CNT_MAX;
      else              r = v + CNT_W'(1);
      return r;
   endfunction

endpackage

[sv/epl_label_unit.sv]
module epl_label_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  epl_pkg::unit_cmd_type             cmd,
   output logic [epl_pkg::CNT_W-1:0]         largest
);

   logic [epl_pkg::CNT_W-1:0] counts_ff [epl_pkg::LABEL_SLOTS];
   logic [epl_pkg::CNT_W-1:0] largest_ff;
   logic [epl_pkg::CNT_W-1:0] rd_data;
   logic [epl_pkg::CNT_W-1:0] base;

   assign rd_data = counts_ff[cmd.idx];
   assign base    = cmd.scan_first ? '0 : largest_ff;
   assign largest = largest_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < epl_pkg::LABEL_SLOTS; k++) begin
            counts_ff[k] <= '0;
         end
         largest_ff <= '0;
      end else begin
         if (cmd.inc) begin
            counts_ff[cmd.idx] <= epl_pkg::sat_inc(rd_data);
         end else if (cmd.scan) begin
            counts_ff[cmd.idx] <= '0;
         end
         if (cmd.scan) begin
            largest_ff <= (cmd.in_use && (rd_data > base)) ? rd_data : base;
         end
      end
   end

endmodule

[sv/equivalent_points_lower_bound_top.sv]
// Channel  Direction  Ports                                         Handshake
// req      in         req_group_id, req_class_label, req_last_item  req_valid / req_ready
// rsp      out        rsp_lower_bound                               rsp_valid / rsp_ready
// csr      in         csr_wr_data (labels_in_use)                   csr_wr_en, no wait
//
// An item within the open group is counted in ST_COUNT. An item that closes a group
// passes ST_CLOSE, ST_ADD and ST_COUNT: the shared compare unit scans one label count per cycle.
// A last item adds one more scan before ST_EMIT.
// Synchronous active-high reset clears counts, bound and the open group.
// A pending result is held in its output register; a new last item waits for it.
module equivalent_points_lower_bound_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [epl_pkg::GROUP_W-1:0]        req_group_id,
   input  logic [epl_pkg::LABEL_W-1:0]        req_class_label,
   input  logic                               req_last_item,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [epl_pkg::CNT_W-1:0]          rsp_lower_bound,
   input  logic                               csr_wr_en,
   input  logic [epl_pkg::USED_W-1:0]         csr_wr_data
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_CLOSE, ST_ADD, ST_COUNT, ST_EMIT
   } state_type;

   localparam logic [epl_pkg::USED_W-1:0]  USED_MAX = epl_pkg::USED_W'(epl_pkg::LABEL_SLOTS);
   localparam logic [epl_pkg::LABEL_W-1:0] SCAN_END = epl_pkg::LABEL_W'(epl_pkg::LABEL_SLOTS - 1);
   localparam logic [epl_pkg::LABEL_W:0]   USED_W_NUM =
      (epl_pkg::LABEL_W + 1)'(epl_pkg::LABEL_SLOTS);

   state_type                        state_ff;
   logic [epl_pkg::USED_W-1:0]       used_ff;
   logic [epl_pkg::GROUP_W-1:0]      gid_ff;
   logic [epl_pkg::LABEL_W-1:0]      lbl_ff;
   logic                             last_ff;
   logic                             final_pass_ff;
   logic [epl_pkg::GROUP_W-1:0]      cur_group_ff;
   logic                             first_seen_ff;
   logic [epl_pkg::CNT_W-1:0]        group_size_ff;
   logic [epl_pkg::CNT_W-1:0]        bound_ff;
   logic [epl_pkg::LABEL_W-1:0]      scan_cnt_ff;
   logic                             rsp_valid_ff;
   logic [epl_pkg::CNT_W-1:0]        rsp_bound_ff;

   epl_pkg::unit_cmd_type            cmd;
   logic [epl_pkg::CNT_W-1:0]        largest;
   logic [epl_pkg::CNT_W-1:0]        eff_max;
   logic [epl_pkg::CNT_W:0]          bound_sum;
   logic [epl_pkg::USED_W-1:0]       used_eff;
   logic                             accept;

   assign req_ready       = (state_ff == ST_IDLE);
   assign accept          = req_valid && req_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_lower_bound = rsp_bound_ff;

   assign used_eff  = (used_ff > USED_MAX) ? USED_MAX : used_ff;
   assign eff_max   = (largest > group_size_ff) ? group_size_ff : largest;
   assign bound_sum = {1'b0, bound_ff} + {1'b0, group_size_ff - eff_max};

   always_comb begin
      cmd            = '0;
      cmd.scan       = (state_ff == ST_CLOSE);
      cmd.scan_first = (scan_cnt_ff == '0);
      cmd.in_use     = {1'b0, scan_cnt_ff} < used_eff;
      cmd.idx        = scan_cnt_ff;
      if (state_ff == ST_COUNT) begin
         cmd.idx = lbl_ff;
         cmd.inc = ({1'b0, lbl_ff} < USED_W_NUM);
      end
   end

   epl_label_unit u_label_unit (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .largest (largest)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= USED_MAX;
      end else if (csr_wr_en) begin
         used_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         gid_ff  <= req_group_id;
         lbl_ff  <= req_class_label;
         last_ff <= req_last_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         final_pass_ff <= 1'b0;
         cur_group_ff  <= '0;
         first_seen_ff <= 1'b0;
         group_size_ff <= '0;
         bound_ff      <= '0;
         scan_cnt_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_bound_ff  <= '0;
      end else begin
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  scan_cnt_ff   <= '0;
                  final_pass_ff <= 1'b0;
                  if (first_seen_ff && (req_group_id != cur_group_ff)) begin
                     state_ff <= ST_CLOSE;
                  end else begin
                     state_ff <= ST_COUNT;
                  end
               end
            end
            ST_CLOSE: begin
               scan_cnt_ff <= scan_cnt_ff + epl_pkg::LABEL_W'(1);
               if (scan_cnt_ff == SCAN_END) begin
                  state_ff <= ST_ADD;
               end
            end
            ST_ADD: begin
               if (group_size_ff > epl_pkg::CNT_W'(1)) begin
                  bound_ff <= (bound_sum > {1'b0, epl_pkg::CNT_MAX}) ?
                              epl_pkg::CNT_MAX : bound_sum[epl_pkg::CNT_W-1:0];
               end
               group_size_ff <= '0;
               state_ff      <= final_pass_ff ? ST_EMIT : ST_COUNT;
            end
            ST_COUNT: begin
               group_size_ff <= epl_pkg::sat_inc(group_size_ff);
               cur_group_ff  <= gid_ff;
               first_seen_ff <= 1'b1;
               scan_cnt_ff   <= '0;
               if (last_ff) begin
                  final_pass_ff <= 1'b1;
                  state_ff      <= ST_CLOSE;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_EMIT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_bound_ff  <= bound_ff;
                  bound_ff      <= '0;
                  first_seen_ff <= 1'b0;
                  cur_group_ff  <= '0;
                  final_pass_ff <= 1'b0;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_EMIT))
      else $error("result raised outside emit");

   a_group_size_sat: assert property (@(posedge clock) disable iff (reset)
      group_size_ff <= epl_pkg::CNT_MAX)
      else $error("group size beyond saturation");

   a_bound_sat: assert property (@(posedge clock) disable iff (reset)
      bound_ff <= epl_pkg::CNT_MAX)
      else $error("bound beyond saturation");

   a_count_marks_seen: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COUNT) |=> first_seen_ff && (group_size_ff != '0))
      else $error("counted item not recorded");

   a_add_clears_size: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADD) |=> (group_size_ff == '0))
      else $error("group size not cleared after close");
`endif

endmodule
